FILE: design/lhbp_pkg.sv
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared constants, types and the counter update for the local history
// branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

	localparam int HIST_BITS_DEF = 10;
	localparam int PC_W          = 32;
	localparam int CTR_W         = 2;

	typedef logic [CTR_W-1:0] ctr_t;

	localparam ctr_t CTR_STRONG_NT = 2'd0;
	localparam ctr_t CTR_WEAK_T    = 2'd2;
	localparam ctr_t CTR_STRONG_T  = 2'd3;

	typedef enum logic {
		OP_PREDICT = 1'b0,
		OP_RESOLVE = 1'b1
	} op_t;

	function automatic ctr_t ctr_next(input ctr_t c, input logic t);
		ctr_t r;
		if (t) begin
			r = (c == CTR_STRONG_T) ? CTR_STRONG_T : ctr_t'(c + 2'd1);
		end else begin
			r = (c == CTR_STRONG_NT) ? CTR_STRONG_NT : ctr_t'(c - 2'd1);
		end
		return r;
	endfunction

endpackage

FILE: design/lhbp_if.sv
// ----------------------------------------------------------------------------
// lhbp_if
// Valid/ready channels of the predictor: branch requests in, predictions out.
// ----------------------------------------------------------------------------
interface lhbp_req_if;
	import lhbp_pkg::*;

	logic            valid;
	logic            ready;
	logic            op;
	logic [PC_W-1:0] pc;
	logic            taken;

	modport source (output valid, output op, output pc, output taken, input ready);
	modport sink (input valid, input op, input pc, input taken, output ready);
endinterface

interface lhbp_rsp_if;
	logic valid;
	logic ready;
	logic predict_taken;

	modport source (output valid, output predict_taken, input ready);
	modport sink (input valid, input predict_taken, output ready);
endinterface

FILE: design/lhbp_ram.sv
// ----------------------------------------------------------------------------
// lhbp_ram
// Single-clock table memory with one write port and one read port; the read
// data is registered and holds while no read is issued.
// ----------------------------------------------------------------------------
module lhbp_ram
	import lhbp_pkg::*;
#(
	parameter int AW = HIST_BITS_DEF,
	parameter int DW = HIST_BITS_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/local_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Two-level local branch predictor with 2-bit saturating counters.
// ----------------------------------------------------------------------------
// Each request is handled in order by the transfer cycle, which reads the local
// history, the history state, which reads the pattern counter addressed by that
// history, and the counter state, which forms the prediction and, for a
// resolve, writes the counter and the shifted history back. The two dependent
// reads of the registered table memories set this sequence. After reset both
// tables are cleared over all 2^HIST_BITS entries (1024 by default), during
// which no request is taken. A finished prediction waits in an output
// register, so a new request is taken while the previous result is still
// unclaimed; that request then stays in the counter state until the waiting
// result is transferred.
module local_history_branch_predictor
	import lhbp_pkg::*;
#(
	parameter int HIST_BITS = HIST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lhbp_req_if.sink    req,
	lhbp_rsp_if.source  rsp
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HIST,
		ST_CTR
	} state_t;

	state_t               state_q;
	logic [HIST_BITS-1:0] clr_q;
	logic [HIST_BITS-1:0] hidx_q;
	logic                 op_q;
	logic                 taken_q;
	logic                 out_valid_q;
	logic                 pred_q;

	logic                 hist_we;
	logic [HIST_BITS-1:0] hist_waddr;
	logic [HIST_BITS-1:0] hist_wdata;
	logic                 hist_re;
	logic [HIST_BITS-1:0] hist_rdata;

	logic                 ctr_we;
	logic [HIST_BITS-1:0] ctr_waddr;
	ctr_t                 ctr_wdata;
	logic                 ctr_re;
	ctr_t                 ctr_rdata;

	logic                 accept;
	logic                 finish;
	logic                 update;

	assign accept  = req.valid && req.ready;
	assign finish  = (state_q == ST_CTR) && (!out_valid_q || rsp.ready);
	assign update  = finish && (op_q == OP_RESOLVE);
	assign hist_re = accept;
	assign ctr_re  = (state_q == ST_HIST);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			hist_we    = 1'b1;
			hist_waddr = clr_q;
			hist_wdata = '0;
			ctr_we     = 1'b1;
			ctr_waddr  = clr_q;
			ctr_wdata  = CTR_STRONG_NT;
		end else begin
			hist_we    = update;
			hist_waddr = hidx_q;
			hist_wdata = HIST_BITS'({hist_rdata, taken_q});
			ctr_we     = update;
			ctr_waddr  = hist_rdata;
			ctr_wdata  = ctr_next(ctr_rdata, taken_q);
		end
	end

	lhbp_ram #(
		.AW (HIST_BITS),
		.DW (HIST_BITS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (req.pc[HIST_BITS-1:0]),
		.rdata (hist_rdata)
	);

	lhbp_ram #(
		.AW (HIST_BITS),
		.DW (CTR_W)
	) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (ctr_waddr),
		.wdata (ctr_wdata),
		.re    (ctr_re),
		.raddr (hist_rdata),
		.rdata (ctr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HIST;
					end
				end
				ST_HIST: begin
					state_q <= ST_CTR;
				end
				ST_CTR: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hidx_q  <= req.pc[HIST_BITS-1:0];
			op_q    <= req.op;
			taken_q <= req.taken;
		end
		if (finish) begin
			pred_q <= (ctr_rdata >= CTR_WEAK_T);
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.predict_taken = pred_q;

	a_accept_reads_history: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_HIST))
		else $error("accepted request did not advance to the history read");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(hist_we && hist_re) && !(ctr_we && ctr_re))
		else $error("table written while a read of it is issued");

	a_result_from_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_CTR))
		else $error("result appeared without a completed lookup");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CTR && out_valid_q && !rsp.ready) |=> (state_q == ST_CTR))
		else $error("lookup finished over an unclaimed result");

endmodule
